### sv/rgbhsl_pkg.sv
// Shared types and constants for the RGB to HSL pixel pipeline.
package rgbhsl_pkg;

  // Channel and field widths
  localparam int CH_W    = 8;                 // one color channel
  localparam int DEN_W   = CH_W + 1;          // divisor, up to 256
  localparam int REM_W   = CH_W + 1;          // partial remainder, at most the divisor
  localparam int QUO_W   = CH_W;              // saturation quotient bits
  localparam int NUM_W   = CH_W + 4;          // signed hue numerator, -255..1275
  localparam int MAG_W   = NUM_W - 1;         // hue numerator magnitude
  localparam int HUE_W   = 9;                 // signed scaled hue

  // Divide by six as multiply by ceil(2^18/6), exact for magnitudes below 2^16
  localparam int              RECIP_W   = 16;
  localparam logic [RECIP_W-1:0] HUE_RECIP = 16'd43691;
  localparam int              HUE_SHIFT = 18;
  localparam int              PROD_W    = MAG_W + RECIP_W;

  // Number of divider cells in the chain
  localparam int NUM_CELLS = QUO_W;

  // Payload that moves along the divider chain
  typedef struct packed {
    logic [REM_W-1:0] rem;       // partial remainder
    logic [DEN_W-1:0] den;       // saturation divisor
    logic [QUO_W-1:0] quo;       // quotient bits so far
    logic             sat_max;   // quotient would reach 256 or more
    logic [MAG_W-1:0] num_mag;   // hue numerator magnitude
    logic             num_neg;   // hue numerator sign
    logic [CH_W-1:0]  light;
    logic [CH_W-1:0]  mult;
  } cell_data_t;

  // Payload after the hue multiply
  typedef struct packed {
    logic [PROD_W-1:0] prod;     // magnitude times reciprocal
    logic              num_neg;
    logic [QUO_W-1:0]  quo;
    logic              sat_max;
    logic [CH_W-1:0]   light;
    logic [CH_W-1:0]   mult;
  } mul_data_t;

endpackage

### sv/rgbhsl_front.sv
// Front stage: channel max/min, divisor, hue numerator and lightness.
module rgbhsl_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  logic                      in_valid,
  input  logic [23:0]               pixel_rgb,
  output logic                      out_valid,
  output rgbhsl_pkg::cell_data_t    out_data
);
  import rgbhsl_pkg::*;

  logic [CH_W-1:0]  r, g, b, hi, lo, d;
  logic             red_max, green_max;
  logic [CH_W:0]    s;
  logic [DEN_W-1:0] den, den_eff;
  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] num_abs;
  cell_data_t       data_next;

  assign r = pixel_rgb[23:16];
  assign g = pixel_rgb[15:8];
  assign b = pixel_rgb[7:0];

  // Maximum with red over green over blue on ties
  always_comb begin
    red_max   = (r >= g) && (r >= b);
    green_max = !red_max && (g >= b);
    if (red_max) begin
      hi = r;
    end else if (green_max) begin
      hi = g;
    end else begin
      hi = b;
    end
    lo = r;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
  end

  assign d = hi - lo;
  assign s = {1'b0, hi} + {1'b0, lo};

  // Divisor mirrors around mid gray; a gray pixel divides by one to give zero
  always_comb begin
    if (s[CH_W]) begin
      den = DEN_W'(10'd512 - {1'b0, s});
    end else begin
      den = DEN_W'(s);
    end
    den_eff = (d == '0) ? DEN_W'(1) : den;
  end

  // Hue numerator per sector
  always_comb begin
    if (red_max) begin
      num = NUM_W'({4'b0, g}) - NUM_W'({4'b0, b});
    end else if (green_max) begin
      num = NUM_W'({d, 1'b0}) + NUM_W'({4'b0, b}) - NUM_W'({4'b0, r});
    end else begin
      num = NUM_W'({d, 2'b0}) + NUM_W'({4'b0, r}) - NUM_W'({4'b0, g});
    end
    num_abs = num[NUM_W-1] ? (~num + NUM_W'(1)) : num;
  end

  always_comb begin
    data_next.rem     = REM_W'(d);
    data_next.den     = den_eff;
    data_next.quo     = '0;
    data_next.sat_max = ({1'b0, d} >= den_eff);
    data_next.num_mag = num_abs[MAG_W-1:0];
    data_next.num_neg = num[NUM_W-1];
    data_next.light   = s[CH_W:1];
    data_next.mult    = (d == '0) ? CH_W'(1) : d;
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
    if (load && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

### sv/rgbhsl_cell.sv
// Divider cell: one restoring step of the saturation quotient per stage.
module rgbhsl_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  logic                      in_valid,
  input  rgbhsl_pkg::cell_data_t    in_data,
  output logic                      out_valid,
  output rgbhsl_pkg::cell_data_t    out_data
);
  import rgbhsl_pkg::*;

  logic [REM_W:0] rem2;
  logic           take;
  cell_data_t     data_next;

  // Shift remainder, subtract divisor when it fits
  always_comb begin
    rem2      = {in_data.rem, 1'b0};
    take      = rem2 >= {1'b0, in_data.den};
    data_next = in_data;
    if (take) begin
      data_next.rem = REM_W'(rem2 - {1'b0, in_data.den});
    end else begin
      data_next.rem = REM_W'(rem2);
    end
    data_next.quo = {in_data.quo[QUO_W-2:0], take};
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
    if (load && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

### sv/rgbhsl_mul.sv
// Hue stage: numerator magnitude times the reciprocal of six.
module rgbhsl_mul (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  logic                      in_valid,
  input  rgbhsl_pkg::cell_data_t    in_data,
  output logic                      out_valid,
  output rgbhsl_pkg::mul_data_t     out_data
);
  import rgbhsl_pkg::*;

  mul_data_t data_next;

  always_comb begin
    data_next.prod    = PROD_W'(in_data.num_mag) * PROD_W'(HUE_RECIP);
    data_next.num_neg = in_data.num_neg;
    data_next.quo     = in_data.quo;
    data_next.sat_max = in_data.sat_max;
    data_next.light   = in_data.light;
    data_next.mult    = in_data.mult;
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
    if (load && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

### sv/rgb_to_hsl_scaled_hue_top.sv
// Top level: RGB888 to HSL with scaled hue, pipelined divider chain.
//
//   Channel | Handshake          | Payload
//   --------+--------------------+--------------------------------------------
//   in      | in_valid/in_stall  | pixel_rgb[23:0]
//   out     | out_valid/out_stall| hue_scaled[8:0] signed, saturation[7:0],
//           |                    | lightness[7:0], hue_multiplier[7:0]
//
// One pixel per clock sustained while out_stall is low. Stages: front,
// eight divider cells (one saturation quotient bit each), hue multiply, output.
// Synchronous reset empties every stage; no item is lost or created.
// A stall on the output fills empty stages first; in_stall rises only
// when every stage holds a transaction and the output is stalled.
module rgb_to_hsl_scaled_hue_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [23:0]                      pixel_rgb,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [rgbhsl_pkg::HUE_W-1:0] hue_scaled,
  output logic [7:0]                       saturation,
  output logic [7:0]                       lightness,
  output logic [7:0]                       hue_multiplier
);
  import rgbhsl_pkg::*;

  // Stage 0 is the front, 1..NUM_CELLS the cells, then multiply, then output
  localparam int MUL_IDX = NUM_CELLS + 1;
  localparam int OUT_IDX = NUM_CELLS + 2;

  logic [OUT_IDX:0]   ready;
  logic [MUL_IDX:0]   vld;
  cell_data_t         cdata [NUM_CELLS+1];
  mul_data_t          mdata;
  logic [HUE_W-1:0]   hue_mag;

  // Stage advances when it is empty or the next stage advances
  always_comb begin
    ready[OUT_IDX] = !out_valid || !out_stall;
    for (int k = MUL_IDX; k >= 0; k--) begin
      ready[k] = !vld[k] || ready[k+1];
    end
  end

  assign in_stall = !ready[0];

  rgbhsl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .load      (ready[0]),
    .in_valid  (in_valid),
    .pixel_rgb (pixel_rgb),
    .out_valid (vld[0]),
    .out_data  (cdata[0])
  );

  // Divider chain
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    rgbhsl_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .load      (ready[i+1]),
      .in_valid  (vld[i]),
      .in_data   (cdata[i]),
      .out_valid (vld[i+1]),
      .out_data  (cdata[i+1])
    );
  end

  rgbhsl_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .load      (ready[MUL_IDX]),
    .in_valid  (vld[NUM_CELLS]),
    .in_data   (cdata[NUM_CELLS]),
    .out_valid (vld[MUL_IDX]),
    .out_data  (mdata)
  );

  // Quotient by six from the product; the sign is restored in the output register
  assign hue_mag = mdata.prod[HUE_SHIFT +: HUE_W];

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready[OUT_IDX]) begin
      out_valid <= vld[MUL_IDX];
    end
    if (ready[OUT_IDX] && vld[MUL_IDX]) begin
      hue_scaled     <= mdata.num_neg ? $signed(~hue_mag + HUE_W'(1)) : $signed(hue_mag);
      saturation     <= mdata.sat_max ? 8'hFF : mdata.quo;
      lightness      <= mdata.light;
      hue_multiplier <= mdata.mult;
    end
  end

  // An accepted pixel always lands in the front stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> vld[0])
    else $error("accepted pixel missing from front stage");

  // Input back-pressure only when the whole pipe is full and blocked
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && (&vld))
    else $error("input stalled with room in the pipeline");

  // Hue stays in its range
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hue_scaled >= -9'sd42) && (hue_scaled <= 9'sd212))
    else $error("hue out of range");

  // Nonzero hue means a colored pixel, which has nonzero saturation
  a_hue_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && (hue_scaled != '0) |-> (saturation != '0))
    else $error("hue without saturation");

endmodule
